// File: hw/rtl/ams_pkg.sv
// ----------------------------------------------------------------------------
// ams_pkg
// Shared types, opcode codes and the control store of the accumulator machine
// stepper.
// ----------------------------------------------------------------------------
package ams_pkg;

	localparam int MEM_DEPTH_DEF  = 256;
	localparam int WORD_WIDTH_DEF = 16;

	// Machine opcodes as they appear in memory
	typedef enum logic [3:0] {
		OP_NONE   = 4'd0,
		OP_ADD    = 4'd1,
		OP_SUB    = 4'd2,
		OP_MULT   = 4'd3,
		OP_DIV    = 4'd4,
		OP_JMP    = 4'd5,
		OP_JMPN   = 4'd6,
		OP_JMPP   = 4'd7,
		OP_JMPZ   = 4'd8,
		OP_COPY   = 4'd9,
		OP_LOAD   = 4'd10,
		OP_STORE  = 4'd11,
		OP_INPUT  = 4'd12,
		OP_OUTPUT = 4'd13,
		OP_STOP   = 4'd14
	} op_t;

	// Control word fields
	typedef enum logic [1:0] {A_PC, A_PC1, A_PC2, A_RD} asel_t;
	typedef enum logic [1:0] {W_NONE, W_SRC, W_OPND} wsel_t;
	typedef enum logic [2:0] {X_NONE, X_ALU, X_DIV_GO, X_DIV_END, X_STOP} exec_t;
	typedef enum logic [1:0] {P_HOLD, P_INC2, P_INC3, P_BRANCH} pcsel_t;
	typedef enum logic [1:0] {S_NEXT, S_DISPATCH, S_WAIT, S_END} seq_t;

	typedef struct packed {
		asel_t  asel;
		wsel_t  wsel;
		logic   ld_ir;
		logic   ld_opnd;
		exec_t  ex;
		pcsel_t pcs;
		seq_t   seq;
	} ucode_t;

	localparam int UPC_W = 5;
	typedef logic [UPC_W-1:0] upc_t;

	// Microcode addresses
	localparam upc_t U_FETCH  = 5'd0;
	localparam upc_t U_DECODE = 5'd1;
	localparam upc_t U_AR0    = 5'd2;
	localparam upc_t U_AR1    = 5'd3;
	localparam upc_t U_AR2    = 5'd4;
	localparam upc_t U_DV0    = 5'd5;
	localparam upc_t U_DV1    = 5'd6;
	localparam upc_t U_DV2    = 5'd7;
	localparam upc_t U_DV3    = 5'd8;
	localparam upc_t U_DV4    = 5'd9;
	localparam upc_t U_BR     = 5'd10;
	localparam upc_t U_CP0    = 5'd11;
	localparam upc_t U_CP1    = 5'd12;
	localparam upc_t U_CP2    = 5'd13;
	localparam upc_t U_ST     = 5'd14;
	localparam upc_t U_HALT   = 5'd15;
	localparam upc_t U_NOP    = 5'd16;

	// Control store
	function automatic ucode_t urom(input upc_t a);
		ucode_t u;
		u = '{A_PC, W_NONE, 1'b0, 1'b0, X_NONE, P_HOLD, S_END};
		case (a)
			U_FETCH:  u = '{A_PC,  W_NONE, 1'b0, 1'b0, X_NONE,    P_HOLD,   S_NEXT};
			U_DECODE: u = '{A_PC1, W_NONE, 1'b1, 1'b0, X_NONE,    P_HOLD,   S_DISPATCH};
			U_AR0:    u = '{A_RD,  W_NONE, 1'b0, 1'b0, X_NONE,    P_HOLD,   S_NEXT};
			U_AR1:    u = '{A_PC,  W_NONE, 1'b0, 1'b1, X_NONE,    P_HOLD,   S_NEXT};
			U_AR2:    u = '{A_PC,  W_NONE, 1'b0, 1'b0, X_ALU,     P_INC2,   S_END};
			U_DV0:    u = '{A_RD,  W_NONE, 1'b0, 1'b0, X_NONE,    P_HOLD,   S_NEXT};
			U_DV1:    u = '{A_PC,  W_NONE, 1'b0, 1'b1, X_NONE,    P_HOLD,   S_NEXT};
			U_DV2:    u = '{A_PC,  W_NONE, 1'b0, 1'b0, X_DIV_GO,  P_HOLD,   S_NEXT};
			U_DV3:    u = '{A_PC,  W_NONE, 1'b0, 1'b0, X_NONE,    P_HOLD,   S_WAIT};
			U_DV4:    u = '{A_PC,  W_NONE, 1'b0, 1'b0, X_DIV_END, P_INC2,   S_END};
			U_BR:     u = '{A_PC,  W_NONE, 1'b0, 1'b0, X_NONE,    P_BRANCH, S_END};
			U_CP0:    u = '{A_RD,  W_NONE, 1'b0, 1'b0, X_NONE,    P_HOLD,   S_NEXT};
			U_CP1:    u = '{A_PC2, W_NONE, 1'b0, 1'b1, X_NONE,    P_HOLD,   S_NEXT};
			U_CP2:    u = '{A_RD,  W_OPND, 1'b0, 1'b0, X_NONE,    P_INC3,   S_END};
			U_ST:     u = '{A_RD,  W_SRC,  1'b0, 1'b0, X_NONE,    P_INC2,   S_END};
			U_HALT:   u = '{A_PC,  W_NONE, 1'b0, 1'b0, X_STOP,    P_HOLD,   S_END};
			U_NOP:    u = '{A_PC,  W_NONE, 1'b0, 1'b0, X_NONE,    P_HOLD,   S_END};
			default:  u = '{A_PC,  W_NONE, 1'b0, 1'b0, X_NONE,    P_HOLD,   S_END};
		endcase
		return u;
	endfunction

	// Entry point of each opcode's routine
	function automatic upc_t dispatch(input op_t op);
		upc_t t;
		t = U_NOP;
		case (op)
			OP_ADD, OP_SUB, OP_MULT, OP_LOAD, OP_OUTPUT: t = U_AR0;
			OP_DIV:                                      t = U_DV0;
			OP_JMP, OP_JMPN, OP_JMPP, OP_JMPZ:           t = U_BR;
			OP_COPY:                                     t = U_CP0;
			OP_STORE, OP_INPUT:                          t = U_ST;
			OP_STOP:                                     t = U_HALT;
			default:                                     t = U_NOP;
		endcase
		return t;
	endfunction

endpackage

// File: hw/rtl/ams_div.sv
// ----------------------------------------------------------------------------
// ams_div
// Signed restoring divider, one quotient bit per cycle, truncating toward
// zero. Result wraps to WIDTH bits.
// ----------------------------------------------------------------------------
module ams_div #(
	parameter int WIDTH = ams_pkg::WORD_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             busy,
	output logic [WIDTH-1:0] quotient
);
	import ams_pkg::*;

	localparam int CW = $clog2(WIDTH + 1);

	logic             busy_q;
	logic [CW-1:0]    cnt_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] dvs_q;
	logic             neg_q;

	logic [WIDTH:0]   r_sh;
	logic [WIDTH:0]   diff;
	logic             ge;

	assign r_sh = {rem_q, quo_q[WIDTH-1]};
	assign diff = r_sh - {1'b0, dvs_q};
	assign ge   = ~diff[WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(WIDTH);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// magnitude of the most negative value is its own bit pattern, unsigned
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend[WIDTH-1] ? -dividend : dividend;
			dvs_q <= divisor[WIDTH-1] ? -divisor : divisor;
			rem_q <= '0;
			neg_q <= dividend[WIDTH-1] ^ divisor[WIDTH-1];
		end else if (busy_q) begin
			rem_q <= ge ? diff[WIDTH-1:0] : r_sh[WIDTH-1:0];
			quo_q <= {quo_q[WIDTH-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = neg_q ? -quo_q : quo_q;

endmodule

// File: hw/rtl/accumulator_machine_stepper.sv
// ----------------------------------------------------------------------------
// accumulator_machine_stepper
// Accumulator machine with one shared code/data memory, run one instruction
// per step command by a microcoded sequencer.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  command | start, busy        | command, address, data
//  result  | done (1-cycle)     | pc, acc, out_valid, out_value, halted,
//          |                    | div_by_zero
//
//  Write command, or step while halted: one cycle, done in the next cycle.
//  Step: one microinstruction per cycle through the single memory port, except
//  while DIV waits on the divider (one quotient bit a cycle); fetch, decode,
//  then the opcode's routine (ADD/SUB/MULT/LOAD/OUTPUT share one), then done.
//  busy is low again in the done cycle, so the next command may start there.
//  Reset clears pc, acc and the halt flag; memory content is kept undefined.
// ----------------------------------------------------------------------------
module accumulator_machine_stepper #(
	parameter int MEM_DEPTH  = ams_pkg::MEM_DEPTH_DEF,
	parameter int WORD_WIDTH = ams_pkg::WORD_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               command,
	input  logic [7:0]         address,
	input  logic signed [15:0] data,
	output logic               done,
	output logic [7:0]         pc,
	output logic signed [15:0] acc,
	output logic               out_valid,
	output logic signed [15:0] out_value,
	output logic               halted,
	output logic               div_by_zero
);
	import ams_pkg::*;

	localparam int AW = $clog2(MEM_DEPTH);
	localparam int WW = WORD_WIDTH;
	localparam int XW = (AW > WW) ? AW : WW;
	localparam int XA = (AW > 8) ? AW : 8;

	// control
	logic           busy_q;
	logic           done_q;
	upc_t           upc_q;
	logic [AW-1:0]  pc_q;
	logic [WW-1:0]  acc_q;
	logic           stopped_q;

	// datapath
	logic [WW-1:0]  mem [MEM_DEPTH];
	logic [WW-1:0]  rdata_q;
	op_t            ir_q;
	logic [WW-1:0]  opnd_q;
	logic [WW-1:0]  data_q;
	logic [7:0]     pc_out_q;
	logic [15:0]    acc_out_q;
	logic           out_valid_q;
	logic [15:0]    out_value_q;
	logic           dz_q;

	ucode_t         uc;
	logic           accept;
	op_t            dec_op;
	logic [XW-1:0]  rd_ext;
	logic [AW-1:0]  rd_addr;
	logic [XA-1:0]  pc_ext;
	logic [XA-1:0]  wa_ext;
	logic [WW-1:0]  data_ext;
	logic [AW-1:0]  mem_addr;
	logic           mem_we;
	logic [WW-1:0]  mem_wdata;
	logic           take;
	logic           div_go;
	logic           div_busy;
	logic [WW-1:0]  div_quo;

	assign uc       = urom(upc_q);
	assign accept   = start && !busy_q;
	assign rd_ext   = XW'(rdata_q);
	assign rd_addr  = rd_ext[AW-1:0];
	assign pc_ext   = XA'(pc_q);
	assign wa_ext   = XA'(address);
	assign data_ext = WW'(data);
	assign div_go   = busy_q && (uc.ex == X_DIV_GO);

	// opcode word compared unsigned: zero, negatives and codes above STOP decode to none
	always_comb begin
		dec_op = OP_NONE;
		if (rdata_q != '0 && rdata_q <= WW'(OP_STOP)) begin
			dec_op = op_t'(rdata_q[3:0]);
		end
	end

	always_comb begin
		case (ir_q)
			OP_JMP:  take = 1'b1;
			OP_JMPN: take = acc_q[WW-1];
			OP_JMPP: take = !acc_q[WW-1] && (acc_q != '0);
			OP_JMPZ: take = (acc_q == '0);
			default: take = 1'b0;
		endcase
	end

	always_comb begin
		mem_addr  = pc_q;
		mem_we    = 1'b0;
		mem_wdata = data_ext;
		if (accept) begin
			mem_addr = wa_ext[AW-1:0];
			mem_we   = !command;
		end else begin
			case (uc.asel)
				A_PC:    mem_addr = pc_q;
				A_PC1:   mem_addr = pc_q + AW'(1);
				A_PC2:   mem_addr = pc_q + AW'(2);
				A_RD:    mem_addr = rd_addr;
				default: mem_addr = pc_q;
			endcase
			mem_we = busy_q && (uc.wsel != W_NONE);
			case (uc.wsel)
				W_OPND:  mem_wdata = opnd_q;
				W_SRC:   mem_wdata = (ir_q == OP_STORE) ? acc_q : data_q;
				default: mem_wdata = opnd_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rdata_q <= mem[mem_addr];
	end

	// sequencer, machine registers and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			upc_q     <= U_FETCH;
			pc_q      <= '0;
			acc_q     <= '0;
			stopped_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				if (!command || stopped_q) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					upc_q  <= U_FETCH;
				end
			end else if (busy_q) begin
				case (uc.seq)
					S_NEXT:     upc_q <= upc_q + UPC_W'(1);
					S_DISPATCH: upc_q <= dispatch(dec_op);
					S_WAIT: begin
						if (!div_busy) begin
							upc_q <= upc_q + UPC_W'(1);
						end
					end
					S_END: begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
					default: upc_q <= U_FETCH;
				endcase

				case (uc.ex)
					X_ALU: begin
						case (ir_q)
							OP_ADD:  acc_q <= acc_q + opnd_q;
							OP_SUB:  acc_q <= acc_q - opnd_q;
							OP_MULT: acc_q <= WW'(acc_q * opnd_q);
							OP_LOAD: acc_q <= opnd_q;
							default: acc_q <= acc_q;
						endcase
					end
					X_DIV_END: begin
						if (opnd_q != '0) begin
							acc_q <= div_quo;
						end
					end
					X_STOP:  stopped_q <= 1'b1;
					default: acc_q <= acc_q;
				endcase

				case (uc.pcs)
					P_INC2:   pc_q <= pc_q + AW'(2);
					P_INC3:   pc_q <= pc_q + AW'(3);
					P_BRANCH: pc_q <= take ? rd_addr : pc_q + AW'(2);
					default:  pc_q <= pc_q;
				endcase
			end
		end
	end

	// transaction payload
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q      <= data_ext;
			pc_out_q    <= pc_ext[7:0];
			acc_out_q   <= 16'(acc_q);
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			dz_q        <= 1'b0;
		end else if (busy_q) begin
			if (uc.ld_ir) begin
				ir_q <= dec_op;
			end
			if (uc.ld_opnd) begin
				opnd_q <= rdata_q;
			end
			if (uc.ex == X_ALU && ir_q == OP_OUTPUT) begin
				out_valid_q <= 1'b1;
				out_value_q <= 16'(opnd_q);
			end
			if (uc.ex == X_DIV_END && opnd_q == '0) begin
				dz_q <= 1'b1;
			end
		end
	end

	ams_div #(
		.WIDTH(WW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (acc_q),
		.divisor  (opnd_q),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	assign busy        = busy_q;
	assign done        = done_q;
	assign pc          = pc_out_q;
	assign acc         = acc_out_q;
	assign out_valid   = out_valid_q;
	assign out_value   = out_value_q;
	assign halted      = stopped_q;
	assign div_by_zero = dz_q;

endmodule

// File: hw/rtl/ams_chk.sv
// ----------------------------------------------------------------------------
// ams_chk
// Port-level checks of the accumulator machine stepper, bound to the top.
// ----------------------------------------------------------------------------
module ams_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               command,
	input logic [7:0]         address,
	input logic signed [15:0] data,
	input logic               done,
	input logic [7:0]         pc,
	input logic signed [15:0] acc,
	input logic               out_valid,
	input logic signed [15:0] out_value,
	input logic               halted,
	input logic               div_by_zero
);

	// result never shows while a step is still running
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// memory write returns its transaction the next cycle with clean flags
	a_write_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !command) |=> (done && !out_valid && !div_by_zero))
		else $error("write transaction result wrong");

	// a step either answers at once (halted) or runs
	a_step_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command) |=> (done || busy))
		else $error("step transaction dropped");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted |=> halted)
		else $error("halt flag cleared");

	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(out_valid && div_by_zero))
		else $error("output and divide fault in one step");

endmodule

bind accumulator_machine_stepper ams_chk u_ams_chk (.*);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for accumulator_machine_stepper. A short table of
// directed transactions (divide overflow, divide by zero, address wrap,
// unknown opcodes) is followed by randomly built programs that are loaded at
// the current pc and stepped, with write noise. The run ends with STOP and
// a few transactions while halted. Every result is checked against an in-bench
// model of the machine, or for typed directed rows against the typed result.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ams_pkg::*;

	localparam bit CMD_WRITE      = 1'b0;
	localparam bit CMD_STEP       = 1'b1;
	localparam int TOTAL_ITEMS    = 1850;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int POOL_WORDS     = 6;

	typedef struct packed {
		logic [7:0]         pc;
		logic signed [15:0] acc;
		logic               out_valid;
		logic signed [15:0] out_value;
		logic               halted;
		logic               div_by_zero;
	} step_result_t;

	typedef struct {
		bit                 cmd;
		logic [7:0]         addr;
		logic signed [15:0] value;
		bit                 typed;
		step_result_t       want;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               command;
	logic [7:0]         address;
	logic signed [15:0] data;
	logic               done;
	logic [7:0]         pc;
	logic signed [15:0] acc;
	logic               out_valid;
	logic signed [15:0] out_value;
	logic               halted;
	logic               div_by_zero;

	accumulator_machine_stepper dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.address     (address),
		.data        (data),
		.done        (done),
		.pc          (pc),
		.acc         (acc),
		.out_valid   (out_valid),
		.out_value   (out_value),
		.halted      (halted),
		.div_by_zero (div_by_zero)
	);

	always #5 clk = ~clk;

	// machine model state
	logic signed [15:0] words [256];
	bit                 word_written [256];
	logic [7:0]         prog_ctr;
	logic signed [15:0] accum;
	bit                 halt_seen;

	step_result_t expected_steps [$];
	stim_row_t    directed_rows [$];

	int errors;
	int n_items, n_writes, n_steps, n_halted_steps, n_div_zero, n_outputs, n_checked;
	bit op_hit [16];
	int stall_cycles;
	logic [7:0] pool_base;
	bit pool_ready;

	task automatic report_error(input string msg);
		$display("ERROR %0t: %s", $time, msg);
		errors++;
	endtask

	function automatic op_t decode_op(input logic signed [15:0] w);
		if (w[15:4] == '0 && w[3:0] <= OP_STOP)
			return op_t'(w[3:0]);
		return OP_NONE;
	endfunction

	// one transaction through the machine model; returns the result it causes
	function automatic step_result_t machine_step(input bit cmd, input logic [7:0] a,
			input logic signed [15:0] d);
		step_result_t r;
		op_t op;
		logic [7:0] p1, ptr, dst, nxt;
		logic signed [15:0] src;
		int quo;
		r = '0;
		r.pc = prog_ctr;
		r.acc = accum;
		if (cmd == CMD_WRITE) begin
			words[a] = d;
			word_written[a] = 1'b1;
			n_writes++;
		end else if (halt_seen) begin
			n_halted_steps++;
		end else begin
			n_steps++;
			op = decode_op(words[prog_ctr]);
			op_hit[op] = 1'b1;
			p1 = prog_ctr + 8'd1;
			ptr = words[p1][7:0];
			src = words[ptr];
			nxt = prog_ctr + 8'd2;
			case (op)
				OP_ADD:  accum = accum + src;
				OP_SUB:  accum = accum - src;
				OP_MULT: accum = accum * src;
				OP_DIV: begin
					if (src == 0) begin
						r.div_by_zero = 1'b1;
						n_div_zero++;
					end else begin
						// 32-bit divide so that -32768 / -1 wraps back cleanly
						quo = int'(accum) / int'(src);
						accum = quo[15:0];
					end
				end
				OP_JMP:  nxt = ptr;
				OP_JMPN: if (accum < 0) nxt = ptr;
				OP_JMPP: if (accum > 0) nxt = ptr;
				OP_JMPZ: if (accum == 0) nxt = ptr;
				OP_COPY: begin
					dst = words[8'(prog_ctr + 8'd2)][7:0];
					words[dst] = src;
					word_written[dst] = 1'b1;
					nxt = prog_ctr + 8'd3;
				end
				OP_LOAD: accum = src;
				OP_STORE: begin
					words[ptr] = accum;
					word_written[ptr] = 1'b1;
				end
				OP_INPUT: begin
					words[ptr] = d;
					word_written[ptr] = 1'b1;
				end
				OP_OUTPUT: begin
					r.out_valid = 1'b1;
					r.out_value = src;
					n_outputs++;
				end
				OP_STOP: begin
					halt_seen = 1'b1;
					nxt = prog_ctr;
				end
				default: nxt = prog_ctr;
			endcase
			prog_ctr = nxt;
		end
		r.halted = halt_seen;
		return r;
	endfunction

	// drive one transaction, wait for acceptance, record what it must return
	task automatic issue(input bit cmd, input logic [7:0] a, input logic signed [15:0] d,
			input bit typed, input step_result_t want);
		int gap;
		bit calm;
		step_result_t pred;
		gap = 0;
		calm = (n_items >= 700 && n_items < 1100);
		if (!calm)
			while ($urandom_range(99) < 12)
				gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		address <= a;
		data <= d;
		@(posedge clk);
		while (busy) @(posedge clk);
		pred = machine_step(cmd, a, d);
		expected_steps.insert(expected_steps.size(), typed ? want : pred);
		n_items++;
	endtask

	task automatic put_word(input logic [7:0] a, input logic signed [15:0] d);
		issue(CMD_WRITE, a, d, 1'b0, '0);
	endtask

	task automatic add_row(input bit cmd, input logic [7:0] a, input logic signed [15:0] d,
			input bit typed, input step_result_t want);
		stim_row_t row;
		row.cmd = cmd;
		row.addr = a;
		row.value = d;
		row.typed = typed;
		row.want = want;
		directed_rows.insert(directed_rows.size(), row);
	endtask

	function automatic logic signed [15:0] pool_value();
		case ($urandom_range(0, 6))
			0: return 16'sd0;
			1: return 16'sd1;
			2: return -16'sd1;
			3: return 16'sh7fff;
			4: return 16'sh8000;
			5: return 16'(int'($urandom_range(0, 16)) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pool_addr();
		if ($urandom_range(99) < 90)
			return pool_base + 8'($urandom_range(0, POOL_WORDS - 1));
		return 8'($urandom);
	endfunction

	// address word; upper byte is sometimes junk to exercise the wrap
	function automatic logic signed [15:0] as_pointer(input logic [7:0] a);
		return {($urandom_range(3) == 0) ? 8'($urandom) : 8'h00, a};
	endfunction

	function automatic logic signed [15:0] junk_opcode();
		logic signed [15:0] w;
		case ($urandom_range(0, 3))
			0: w = 16'(OP_NONE);
			1: w = -16'sd1;
			2: w = 16'(OP_STOP) + 16'sd1;
			default: begin
				w = 16'($urandom);
				if (decode_op(w) != OP_NONE)
					w = 16'sh8000;
			end
		endcase
		return w;
	endfunction

	// first never-written word the next step would read, or -1
	function automatic int unsafe_read();
		logic [7:0] p1, p2, tgt;
		op_t op;
		if (halt_seen)
			return -1;
		if (!word_written[prog_ctr])
			return int'(prog_ctr);
		p1 = prog_ctr + 8'd1;
		p2 = prog_ctr + 8'd2;
		if (!word_written[p1])
			return int'(p1);
		op = decode_op(words[prog_ctr]);
		if (op == OP_COPY && !word_written[p2])
			return int'(p2);
		tgt = words[p1][7:0];
		case (op)
			OP_ADD, OP_SUB, OP_MULT, OP_DIV, OP_LOAD, OP_OUTPUT, OP_COPY:
				if (!word_written[tgt])
					return int'(tgt);
			default: ;
		endcase
		return -1;
	endfunction

	// fill whatever the next step would read uninitialized; unless allow_stop, replace a STOP at pc
	task automatic make_step_safe(input bit allow_stop);
		int a;
		if (!allow_stop && !halt_seen && word_written[prog_ctr] &&
				decode_op(words[prog_ctr]) == OP_STOP)
			put_word(prog_ctr, 16'($urandom_range(OP_ADD, OP_OUTPUT)));
		a = unsafe_read();
		while (a >= 0) begin
			if (a == int'(prog_ctr))
				put_word(8'(a), 16'($urandom_range(OP_ADD, OP_OUTPUT)));
			else
				put_word(8'(a), ($urandom_range(1) == 0) ? as_pointer(pool_addr()) : pool_value());
			a = unsafe_read();
		end
	endtask

	// lay a short random program down at the current pc
	task automatic write_program();
		op_t ops [10];
		logic [7:0] at [10];
		logic [7:0] cur, tgt;
		int len, i;
		len = $urandom_range(2, 10);
		if (!pool_ready || $urandom_range(1) == 1) begin
			pool_base = 8'($urandom);
			for (i = 0; i < POOL_WORDS; i++)
				put_word(pool_base + 8'(i), pool_value());
			pool_ready = 1'b1;
		end
		cur = prog_ctr;
		for (i = 0; i < len; i++) begin
			ops[i] = op_t'($urandom_range(OP_ADD, OP_OUTPUT));
			at[i] = cur;
			cur = cur + ((ops[i] == OP_COPY) ? 8'd3 : 8'd2);
		end
		for (i = 0; i < len; i++) begin
			if ($urandom_range(99) < 3)
				put_word(at[i], junk_opcode());
			else
				put_word(at[i], 16'(ops[i]));
			case (ops[i])
				OP_JMP, OP_JMPN, OP_JMPP, OP_JMPZ: begin
					tgt = ($urandom_range(99) < 90) ? at[$urandom_range(0, len - 1)] : 8'($urandom);
					put_word(at[i] + 8'd1, as_pointer(tgt));
				end
				OP_COPY: begin
					put_word(at[i] + 8'd1, as_pointer(pool_addr()));
					put_word(at[i] + 8'd2, as_pointer(pool_addr()));
				end
				default: put_word(at[i] + 8'd1, as_pointer(pool_addr()));
			endcase
		end
	endtask

	// result checker: done marks a one-cycle result
	always @(posedge clk) begin
		step_result_t want;
		if (arst_n && done) begin
			if (expected_steps.size() == 0) begin
				report_error($sformatf("result with no transaction pending, pc %0d", pc));
			end else begin
				want = expected_steps.pop_front();
				n_checked++;
				if (pc !== want.pc)
					report_error($sformatf("#%0d pc %0d, want %0d", n_checked, pc, want.pc));
				if (acc !== want.acc)
					report_error($sformatf("#%0d acc %0d, want %0d", n_checked, acc, want.acc));
				if (out_valid !== want.out_valid)
					report_error($sformatf("#%0d out_valid %b, want %b", n_checked,
						out_valid, want.out_valid));
				if (out_value !== want.out_value)
					report_error($sformatf("#%0d out_value %0d, want %0d", n_checked,
						out_value, want.out_value));
				if (halted !== want.halted)
					report_error($sformatf("#%0d halted %b, want %b", n_checked,
						halted, want.halted));
				if (div_by_zero !== want.div_by_zero)
					report_error($sformatf("#%0d div_by_zero %b, want %b", n_checked,
						div_by_zero, want.div_by_zero));
			end
		end
	end

	// watchdog: cycles with no transaction moving on either side
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d idle cycles", stall_cycles);
			$display("FAIL accumulator_machine_stepper");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int runs, ops_seen, i;
		arst_n <= 1'b0;
		start <= 1'b0;
		command <= CMD_WRITE;
		address <= '0;
		data <= '0;
		prog_ctr = '0;
		accum = '0;
		halt_seen = 1'b0;
		pool_ready = 1'b0;
		pool_base = '0;

		// data words, then LOAD / DIV by -1 / DIV by 0 / OUTPUT, then unknown opcodes
		add_row(CMD_WRITE, 8'h80, 16'sh8000, 1'b1, step_result_t'('0));
		add_row(CMD_WRITE, 8'hff, -16'sd1, 1'b0, '0);
		add_row(CMD_WRITE, 8'h82, 16'sd0, 1'b0, '0);
		add_row(CMD_WRITE, 8'h00, 16'(OP_LOAD), 1'b0, '0);
		add_row(CMD_WRITE, 8'h01, 16'h0080, 1'b0, '0);
		add_row(CMD_WRITE, 8'h02, 16'(OP_DIV), 1'b0, '0);
		add_row(CMD_WRITE, 8'h03, 16'h01ff, 1'b0, '0);
		add_row(CMD_WRITE, 8'h04, 16'(OP_DIV), 1'b0, '0);
		add_row(CMD_WRITE, 8'h05, 16'hff82, 1'b0, '0);
		add_row(CMD_WRITE, 8'h06, 16'(OP_OUTPUT), 1'b0, '0);
		add_row(CMD_WRITE, 8'h07, 16'h7f80, 1'b0, '0);
		add_row(CMD_WRITE, 8'h08, -16'sd1, 1'b0, '0);
		add_row(CMD_WRITE, 8'h09, 16'sh7fff, 1'b0, '0);
		add_row(CMD_STEP, 8'h00, 16'sh0000, 1'b0, '0);
		add_row(CMD_STEP, 8'hff, 16'shffff, 1'b0, '0);
		add_row(CMD_STEP, 8'h00, 16'sh0000, 1'b1,
			step_result_t'({8'd4, 16'sh8000, 1'b0, 16'sh0000, 1'b0, 1'b1}));
		add_row(CMD_STEP, 8'h00, 16'sh0000, 1'b1,
			step_result_t'({8'd6, 16'sh8000, 1'b1, 16'sh8000, 1'b0, 1'b0}));
		add_row(CMD_STEP, 8'h00, 16'sh0000, 1'b0, '0);
		add_row(CMD_WRITE, 8'h08, 16'(OP_STOP) + 16'sd1, 1'b0, '0);
		add_row(CMD_STEP, 8'h00, 16'sh0000, 1'b0, '0);
		add_row(CMD_WRITE, 8'h08, 16'(OP_NONE), 1'b0, '0);
		add_row(CMD_STEP, 8'h00, 16'sh0000, 1'b0, '0);
		add_row(CMD_WRITE, 8'h08, 16'sh7fff, 1'b0, '0);
		add_row(CMD_STEP, 8'h00, 16'sh0000, 1'b1,
			step_result_t'({8'd8, 16'sh8000, 1'b0, 16'sh0000, 1'b0, 1'b0}));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			issue(directed_rows[i].cmd, directed_rows[i].addr, directed_rows[i].value,
				directed_rows[i].typed, directed_rows[i].want);

		// random programs, stepped from wherever pc sits
		while (n_items < TOTAL_ITEMS) begin
			write_program();
			runs = $urandom_range(6, 40);
			repeat (runs) begin
				if ($urandom_range(99) < 4)
					put_word(8'($urandom), 16'($urandom));
				make_step_safe(1'b0);
				issue(CMD_STEP, 8'($urandom), 16'($urandom), 1'b0, '0);
			end
		end

		// halt the machine, then confirm writes land and steps do nothing
		put_word(prog_ctr, 16'(OP_STOP));
		make_step_safe(1'b1);
		issue(CMD_STEP, 8'($urandom), 16'($urandom), 1'b0, '0);
		repeat (10)
			issue(1'($urandom), 8'($urandom), 16'($urandom), 1'b0, '0);
		start <= 1'b0;

		while (expected_steps.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		ops_seen = 0;
		for (i = 1; i < 16; i++)
			ops_seen += op_hit[i];
		$display("covered %0d transactions: %0d writes, %0d steps, %0d steps while halted,",
			n_items, n_writes, n_steps, n_halted_steps);
		$display("%0d of 14 opcodes run, %0d divides by zero, %0d outputs, %0d results checked",
			ops_seen, n_div_zero, n_outputs, n_checked);
		if (errors == 0)
			$display("PASS accumulator_machine_stepper");
		else
			$display("FAIL accumulator_machine_stepper");
		$finish;
	end

endmodule
